[rtl/iiea_pkg.sv]
// Package for the indexed insert/erase array: command and status codes,
// field widths and the controller-to-datapath command type.
// No dependencies.
package iiea_pkg;

   // default number of cells
   localparam int DEPTH_DEFAULT = 16;

   // fixed field widths
   localparam int CMD_W   = 3;
   localparam int WORD_W  = 32;
   localparam int POS_W   = 5;
   localparam int COUNT_W = 5;
   localparam int STAT_W  = 2;

   // request command codes
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd5;
   localparam logic [CMD_W-1:0] CMD_READ       = 3'd6;

   // response status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

   // datapath operation codes
   localparam logic [1:0] DP_HOLD   = 2'd0;
   localparam logic [1:0] DP_INSERT = 2'd1;
   localparam logic [1:0] DP_ERASE  = 2'd2;
   localparam logic [1:0] DP_READ   = 2'd3;

   // command from controller to datapath
   typedef struct packed {
      logic [1:0] op;
   } dp_cmd_type;

endpackage

[rtl/indexed_insert_erase_array_core.sv]
// Top level of the indexed insert/erase array.
// Instantiates iiea_ctrl and iiea_datapath; depends on iiea_pkg.
//
// Usage:
//   The block holds an ordered array of up to DEPTH signed 32-bit words.
//   A request beat (req_command, req_item_value, req_position) is taken at
//   a rising edge with start high and busy low. Commands: push back, push
//   front, insert at index, pop back, pop front, erase at index, read.
//   Exactly one response beat follows each request: rsp_strobe is high for
//   one cycle, the cycle after the request, with the new count, a status
//   (ok, full, empty, index out of range) and, for a good read, the word.
//   Failed commands leave the array untouched.
//   A new request may be given every cycle: every cell picks its
//   neighbour below, its neighbour above, the new word or itself in one
//   step, so busy stays low. The read word comes through one DEPTH-to-one
//   selector in the datapath.
//   Reset clears the count and the response strobe; cell contents are not
//   cleared, and a cell above the count is never read out.
//   The receiver cannot stall: each response must be taken in its cycle.
module indexed_insert_erase_array_core #(
   parameter int DEPTH = iiea_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [iiea_pkg::CMD_W-1:0]           req_command,
   input  logic signed [iiea_pkg::WORD_W-1:0]   req_item_value,
   input  logic [iiea_pkg::POS_W-1:0]           req_position,
   output logic                                 rsp_strobe,
   output logic [iiea_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic [iiea_pkg::STAT_W-1:0]          rsp_status,
   output logic signed [iiea_pkg::WORD_W-1:0]   rsp_read_word
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int OUT_W = (CNT_W > iiea_pkg::COUNT_W) ? CNT_W : iiea_pkg::COUNT_W;

   iiea_pkg::dp_cmd_type dp_cmd;
   logic [IDX_W-1:0]     index;
   logic [CNT_W-1:0]     count;
   logic [OUT_W-1:0]     count_ext;

   iiea_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .command    (req_command),
      .position   (req_position),
      .count      (count),
      .dp_cmd     (dp_cmd),
      .index      (index),
      .rsp_strobe (rsp_strobe),
      .rsp_status (rsp_status)
   );

   iiea_datapath #(
      .DEPTH(DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (dp_cmd),
      .index     (index),
      .value     (req_item_value),
      .count     (count),
      .read_word (rsp_read_word)
   );

   // count reported in its field width, wrapping for large depths
   assign count_ext       = OUT_W'(count);
   assign rsp_entry_count = count_ext[iiea_pkg::COUNT_W-1:0];

endmodule

[rtl/iiea_datapath.sv]
// Datapath of the indexed insert/erase array: the row of word cells,
// the fill count and the registered read word.
// Depends on iiea_pkg.
module iiea_datapath #(
   parameter int DEPTH = iiea_pkg::DEPTH_DEFAULT,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  iiea_pkg::dp_cmd_type             cmd,
   input  logic [IDX_W-1:0]                 index,
   input  logic signed [iiea_pkg::WORD_W-1:0] value,
   output logic [CNT_W-1:0]                 count,
   output logic signed [iiea_pkg::WORD_W-1:0] read_word
);

   logic signed [iiea_pkg::WORD_W-1:0] entries_ff [DEPTH];
   logic signed [iiea_pkg::WORD_W-1:0] entries_in [DEPTH];
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic signed [iiea_pkg::WORD_W-1:0] read_word_ff, read_word_in;

   // each cell takes its lower neighbour, its upper neighbour, the new word or itself
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [iiea_pkg::WORD_W-1:0] from_below, from_above;
      if (i > 0) begin : g_below
         assign from_below = entries_ff[i-1];
      end else begin : g_no_below
         assign from_below = entries_ff[i];
      end
      if (i < DEPTH - 1) begin : g_above
         assign from_above = entries_ff[i+1];
      end else begin : g_no_above
         assign from_above = entries_ff[i];
      end

      always_comb begin
         entries_in[i] = entries_ff[i];
         case (cmd.op)
            iiea_pkg::DP_INSERT: begin
               if (IDX_W'(i) == index) begin
                  entries_in[i] = value;
               end else if (IDX_W'(i) > index) begin
                  entries_in[i] = from_below;
               end
            end
            iiea_pkg::DP_ERASE: begin
               if (IDX_W'(i) >= index) begin
                  entries_in[i] = from_above;
               end
            end
            default: begin
               entries_in[i] = entries_ff[i];
            end
         endcase
      end

      always_ff @(posedge clock) begin
         entries_ff[i] <= entries_in[i];
      end
   end

   // fill count and read word
   always_comb begin
      count_in     = count_ff;
      read_word_in = '0;
      case (cmd.op)
         iiea_pkg::DP_INSERT: count_in = count_ff + CNT_W'(1);
         iiea_pkg::DP_ERASE:  count_in = count_ff - CNT_W'(1);
         iiea_pkg::DP_READ:   read_word_in = entries_ff[index];
         default:             count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      read_word_ff <= read_word_in;
   end

   assign count     = count_ff;
   assign read_word = read_word_ff;

endmodule

[rtl/iiea_ctrl.sv]
// Controller of the indexed insert/erase array: checks each request
// against the fill count, issues the datapath operation and the response strobe.
// Depends on iiea_pkg.
module iiea_ctrl #(
   parameter int DEPTH = iiea_pkg::DEPTH_DEFAULT,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [iiea_pkg::CMD_W-1:0]    command,
   input  logic [iiea_pkg::POS_W-1:0]    position,
   input  logic [CNT_W-1:0]              count,
   output iiea_pkg::dp_cmd_type          dp_cmd,
   output logic [IDX_W-1:0]              index,
   output logic                          rsp_strobe,
   output logic [iiea_pkg::STAT_W-1:0]   rsp_status
);

   localparam int CMP_W = (CNT_W > iiea_pkg::POS_W) ? CNT_W : iiea_pkg::POS_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RESP = 1'b1;

   logic                        state_ff, state_in;
   logic [iiea_pkg::STAT_W-1:0] status_ff, status_in;
   logic                        accept;
   logic [CMP_W-1:0]            cnt_ext, pos_ext, cnt_dec;
   logic                        full, empty;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign cnt_ext = CMP_W'(count);
   assign pos_ext = CMP_W'(position);
   assign cnt_dec = cnt_ext - CMP_W'(1);
   assign full    = (cnt_ext == CMP_W'(DEPTH));
   assign empty   = (count == '0);

   // request decode and bounds checks
   always_comb begin
      dp_cmd.op = iiea_pkg::DP_HOLD;
      index     = '0;
      status_in = iiea_pkg::STAT_OK;
      if (accept) begin
         case (command)
            iiea_pkg::CMD_PUSH_BACK: begin
               if (full) begin
                  status_in = iiea_pkg::STAT_FULL;
               end else begin
                  dp_cmd.op = iiea_pkg::DP_INSERT;
                  index     = cnt_ext[IDX_W-1:0];
               end
            end
            iiea_pkg::CMD_PUSH_FRONT: begin
               if (full) begin
                  status_in = iiea_pkg::STAT_FULL;
               end else begin
                  dp_cmd.op = iiea_pkg::DP_INSERT;
               end
            end
            iiea_pkg::CMD_INSERT: begin
               if (full) begin
                  status_in = iiea_pkg::STAT_FULL;
               end else if (pos_ext > cnt_ext) begin
                  status_in = iiea_pkg::STAT_RANGE;
               end else begin
                  dp_cmd.op = iiea_pkg::DP_INSERT;
                  index     = pos_ext[IDX_W-1:0];
               end
            end
            iiea_pkg::CMD_POP_BACK: begin
               if (empty) begin
                  status_in = iiea_pkg::STAT_EMPTY;
               end else begin
                  dp_cmd.op = iiea_pkg::DP_ERASE;
                  index     = cnt_dec[IDX_W-1:0];
               end
            end
            iiea_pkg::CMD_POP_FRONT: begin
               if (empty) begin
                  status_in = iiea_pkg::STAT_EMPTY;
               end else begin
                  dp_cmd.op = iiea_pkg::DP_ERASE;
               end
            end
            iiea_pkg::CMD_ERASE: begin
               if (empty) begin
                  status_in = iiea_pkg::STAT_EMPTY;
               end else if (pos_ext >= cnt_ext) begin
                  status_in = iiea_pkg::STAT_RANGE;
               end else begin
                  dp_cmd.op = iiea_pkg::DP_ERASE;
                  index     = pos_ext[IDX_W-1:0];
               end
            end
            iiea_pkg::CMD_READ: begin
               // below the count implies below the depth
               if (pos_ext < cnt_ext) begin
                  dp_cmd.op = iiea_pkg::DP_READ;
                  index     = pos_ext[IDX_W-1:0];
               end else begin
                  status_in = iiea_pkg::STAT_RANGE;
               end
            end
            default: begin
               // unused code: no change, status ok
               dp_cmd.op = iiea_pkg::DP_HOLD;
            end
         endcase
      end
   end

   // response state: one strobe cycle after each accepted beat
   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = accept ? ST_RESP : ST_IDLE;
         ST_RESP: state_in = accept ? ST_RESP : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      status_ff <= status_in;
   end

   assign rsp_strobe = (state_ff == ST_RESP);
   assign rsp_status = status_ff;

endmodule
